@@ rtl/skyp_pkg.sv @@
package skyp_pkg;

   localparam int MAX_SEGMENTS_DEF = 256;

   localparam logic [1:0] ACT_RESET  = 2'd0;
   localparam logic [1:0] ACT_ADD    = 2'd1;
   localparam logic [1:0] ACT_EXPAND = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [14:0] req_width;
      logic [14:0] req_height;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [14:0] place_x;
      logic [14:0] place_y;
   } rsp_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] w;
   } seg_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_RESET_SKY,
      CMD_EXPAND,
      CMD_SRCH_INIT,
      CMD_RD_S,
      CMD_CHK_S,
      CMD_NEXT_S,
      CMD_RD_K,
      CMD_WALK,
      CMD_EVAL,
      CMD_INS_INIT,
      CMD_INS_RD,
      CMD_INS_WR,
      CMD_INS_PUT,
      CMD_TRIM_RD,
      CMD_TRIM_FIT,
      CMD_TRIM_DROP,
      CMD_DROP_RD,
      CMD_DROP_WR,
      CMD_DROP_FIN,
      CMD_MERGE_INIT,
      CMD_MERGE_RD,
      CMD_MERGE_RD2,
      CMD_MERGE_JOIN,
      CMD_MERGE_NEXT,
      CMD_SEND
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [1:0] code;
   } ctl_type;

   typedef struct packed {
      logic [1:0] act;
      logic       exp_full;
      logic       full;
      logic       s_end;
      logic       chk_fail;
      logic       left_zero;
      logic       k_end;
      logic       walk_fail;
      logic       walk_more;
      logic       found;
      logic       ins_at_pos;
      logic       trim_stop;
      logic       trim_drop;
      logic       drop_end;
      logic       m_end;
      logic       m_eq;
      logic       rsp_busy;
   } dp_stat_type;

   function automatic logic [15:0] sat16(input logic [16:0] v);
      sat16 = v[16] ? 16'hFFFF : v[15:0];
   endfunction

endpackage

@@ rtl/skyline_rect_packer_top.sv @@
// Skyline rectangle packer, bottom-left best fit.
// Input channel (req_*): one transaction per request: action 0 resets the
// skyline to one full-width segment, 1 places a rectangle, 2 resizes the atlas.
// Result channel (rsp_*): exactly one transaction per request, in order,
// carrying status (ok, no space, table full) and the placed position.
// An add runs a fit search over every start segment, walking the segments
// it spans, then shifts entries up on insert and down for each dropped or
// merged segment, and runs a merge pass; the controller reads or writes
// one segment memory entry per cycle.
// One request is in work at a time; req_ready is high only while idle.
// The result sits in an output register, so a new request is taken while a
// result waits; if the receiver stalls, the next result holds in the
// controller until the register frees.
// Reset clears the segment count and atlas size; the segment memory itself
// is not cleared and needs no clearing pass.
module skyline_rect_packer_top #(
   parameter int MaxSegments = skyp_pkg::MAX_SEGMENTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  skyp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output skyp_pkg::rsp_type rsp_data
);
   import skyp_pkg::*;

   ctl_type     ctl;
   dp_stat_type stat;

   // sequence the search, insert, trim and merge passes
   skyp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // hold segment memory, skyline registers and the result register
   skyp_datapath #(.MaxSegments(MaxSegments)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/skyp_ctrl.sv @@
module skyp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  skyp_pkg::dp_stat_type stat,
   output skyp_pkg::ctl_type     ctl
);
   import skyp_pkg::*;

   typedef enum logic [4:0] {
      IDLE, DISPATCH, FINISH,
      SRD, SCHK, WRD, WSTEP, SEVAL, SDONE,
      IRD, IWR, TRD, TCHK, MINIT,
      DRD, DWR, MRD, MRD2, MCHK
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] code_ff, code_in;
   logic       ret_merge_ff, ret_merge_in;

   assign req_ready = (state_ff == IDLE);

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      ret_merge_in = ret_merge_ff;
      ctl.cmd      = CMD_NONE;
      ctl.code     = code_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               ctl.cmd  = CMD_LOAD;
               state_in = DISPATCH;
            end
         end
         DISPATCH: begin
            code_in  = ST_OK;
            state_in = FINISH;
            unique case (stat.act)
               ACT_RESET: ctl.cmd = CMD_RESET_SKY;
               ACT_EXPAND: begin
                  if (stat.exp_full) code_in = ST_FULL;
                  else ctl.cmd = CMD_EXPAND;
               end
               ACT_ADD: begin
                  ctl.cmd  = CMD_SRCH_INIT;
                  state_in = SRD;
               end
               default: ;
            endcase
         end
         FINISH: begin
            if (!stat.rsp_busy) begin
               ctl.cmd  = CMD_SEND;
               state_in = IDLE;
            end
         end
         SRD: begin
            if (stat.s_end) state_in = SDONE;
            else begin
               ctl.cmd  = CMD_RD_S;
               state_in = SCHK;
            end
         end
         SCHK: begin
            if (stat.chk_fail) begin
               ctl.cmd  = CMD_NEXT_S;
               state_in = SRD;
            end else begin
               ctl.cmd  = CMD_CHK_S;
               state_in = stat.left_zero ? SEVAL : WRD;
            end
         end
         WRD: begin
            if (stat.k_end) begin
               ctl.cmd  = CMD_NEXT_S;
               state_in = SRD;
            end else begin
               ctl.cmd  = CMD_RD_K;
               state_in = WSTEP;
            end
         end
         WSTEP: begin
            if (stat.walk_fail) begin
               ctl.cmd  = CMD_NEXT_S;
               state_in = SRD;
            end else begin
               ctl.cmd  = CMD_WALK;
               state_in = stat.walk_more ? WRD : SEVAL;
            end
         end
         SEVAL: begin
            ctl.cmd  = CMD_EVAL;
            state_in = SRD;
         end
         SDONE: begin
            if (!stat.found) begin
               code_in  = ST_NOSPACE;
               state_in = FINISH;
            end else if (stat.full) begin
               code_in  = ST_FULL;
               state_in = FINISH;
            end else begin
               ctl.cmd  = CMD_INS_INIT;
               state_in = IRD;
            end
         end
         IRD: begin
            if (stat.ins_at_pos) begin
               ctl.cmd  = CMD_INS_PUT;
               state_in = TRD;
            end else begin
               ctl.cmd  = CMD_INS_RD;
               state_in = IWR;
            end
         end
         IWR: begin
            ctl.cmd  = CMD_INS_WR;
            state_in = IRD;
         end
         TRD: begin
            if (stat.k_end) state_in = MINIT;
            else begin
               ctl.cmd  = CMD_TRIM_RD;
               state_in = TCHK;
            end
         end
         TCHK: begin
            if (stat.trim_stop) state_in = MINIT;
            else if (stat.trim_drop) begin
               ctl.cmd      = CMD_TRIM_DROP;
               ret_merge_in = 1'b0;
               state_in     = DRD;
            end else begin
               ctl.cmd  = CMD_TRIM_FIT;
               state_in = MINIT;
            end
         end
         MINIT: begin
            ctl.cmd  = CMD_MERGE_INIT;
            state_in = MRD;
         end
         DRD: begin
            if (stat.drop_end) begin
               ctl.cmd  = CMD_DROP_FIN;
               state_in = ret_merge_ff ? MRD : TRD;
            end else begin
               ctl.cmd  = CMD_DROP_RD;
               state_in = DWR;
            end
         end
         DWR: begin
            ctl.cmd  = CMD_DROP_WR;
            state_in = DRD;
         end
         MRD: begin
            if (stat.m_end) begin
               code_in  = ST_OK;
               state_in = FINISH;
            end else begin
               ctl.cmd  = CMD_MERGE_RD;
               state_in = MRD2;
            end
         end
         MRD2: begin
            ctl.cmd  = CMD_MERGE_RD2;
            state_in = MCHK;
         end
         MCHK: begin
            if (stat.m_eq) begin
               ctl.cmd      = CMD_MERGE_JOIN;
               ret_merge_in = 1'b1;
               state_in     = DRD;
            end else begin
               ctl.cmd  = CMD_MERGE_NEXT;
               state_in = MRD;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         code_ff      <= ST_OK;
         ret_merge_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         ret_merge_ff <= ret_merge_in;
      end
   end

endmodule

@@ rtl/skyp_datapath.sv @@
module skyp_datapath #(
   parameter int MaxSegments = skyp_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  skyp_pkg::req_type     req_data,
   input  skyp_pkg::ctl_type     ctl,
   output skyp_pkg::dp_stat_type stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output skyp_pkg::rsp_type     rsp_data
);
   import skyp_pkg::*;

   localparam int IW = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;
   localparam int CW = $clog2(MaxSegments + 1);

   seg_type mem [MaxSegments];
   seg_type rd_ff;

   logic [CW-1:0] cnt_ff, s_ff, k_ff, j_ff, best_i_ff;
   logic [15:0]   aw_ff, ah_ff;
   logic [1:0]    act_ff;
   logic [14:0]   rw_ff, rh_ff;
   logic [15:0]   y_ff, sw_ff, sx_ff, best_w_ff, best_x_ff, best_y_ff;
   logic signed [17:0] left_ff;
   logic [16:0]   best_top_ff, pe_ff;
   logic          found_ff;
   seg_type       new_ff, cur_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic               rd_en, wr_en;
   logic [IW-1:0]      rd_addr, wr_addr;
   seg_type            wr_data;
   logic [16:0]        x_plus_w, ny_top, top, wsum;
   logic [15:0]        ny;
   logic signed [17:0] left_nx, nw;
   logic               better;
   logic [CW:0]        j_next, k_next;

   always_comb begin
      x_plus_w = {1'b0, rd_ff.x} + {2'b0, rw_ff};
      ny       = (rd_ff.y > y_ff) ? rd_ff.y : y_ff;
      ny_top   = {1'b0, ny} + {2'b0, rh_ff};
      left_nx  = left_ff - $signed({2'b0, rd_ff.w});
      top      = {1'b0, y_ff} + {2'b0, rh_ff};
      better   = (top < best_top_ff) || ((top == best_top_ff) && (sw_ff < best_w_ff));
      nw       = $signed({2'b0, rd_ff.w}) + $signed({2'b0, rd_ff.x})
                 - $signed({1'b0, pe_ff});
      wsum     = {1'b0, cur_ff.w} + {1'b0, rd_ff.w};
      j_next   = {1'b0, j_ff} + (CW+1)'(1);
      k_next   = {1'b0, k_ff} + (CW+1)'(1);

      stat.act        = act_ff;
      stat.full       = (cnt_ff >= CW'(MaxSegments));
      stat.exp_full   = ({1'b0, rw_ff} > aw_ff) && stat.full;
      stat.s_end      = (s_ff >= cnt_ff);
      stat.chk_fail   = (x_plus_w > {1'b0, aw_ff});
      stat.left_zero  = (rw_ff == 15'd0);
      stat.k_end      = (k_ff >= cnt_ff);
      stat.walk_fail  = (ny_top > {1'b0, ah_ff});
      stat.walk_more  = (left_nx > 18'sd0);
      stat.found      = found_ff;
      stat.ins_at_pos = (k_ff == best_i_ff);
      stat.trim_stop  = ({1'b0, rd_ff.x} >= pe_ff);
      stat.trim_drop  = (nw <= 18'sd0);
      stat.drop_end   = (j_next >= {1'b0, cnt_ff});
      stat.m_end      = (k_next >= {1'b0, cnt_ff});
      stat.m_eq       = (cur_ff.y == rd_ff.y);
      stat.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   // memory port steering
   always_comb begin
      rd_en   = 1'b1;
      wr_en   = 1'b0;
      rd_addr = k_ff[IW-1:0];
      wr_addr = k_ff[IW-1:0];
      wr_data = rd_ff;
      case (ctl.cmd)
         CMD_RD_S:      rd_addr = s_ff[IW-1:0];
         CMD_INS_RD:    rd_addr = IW'(k_ff - CW'(1));
         CMD_DROP_RD:   rd_addr = j_next[IW-1:0];
         CMD_MERGE_RD2: rd_addr = k_next[IW-1:0];
         CMD_RD_K, CMD_TRIM_RD, CMD_MERGE_RD: rd_addr = k_ff[IW-1:0];
         default:       rd_en = 1'b0;
      endcase
      case (ctl.cmd)
         CMD_RESET_SKY: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = '{x: 16'd0, y: 16'd0, w: {1'b0, rw_ff}};
         end
         CMD_EXPAND: begin
            wr_en   = ({1'b0, rw_ff} > aw_ff);
            wr_addr = cnt_ff[IW-1:0];
            wr_data = '{x: aw_ff, y: 16'd0, w: {1'b0, rw_ff} - aw_ff};
         end
         CMD_INS_WR: wr_en = 1'b1;
         CMD_INS_PUT: begin
            wr_en   = 1'b1;
            wr_addr = best_i_ff[IW-1:0];
            wr_data = new_ff;
         end
         CMD_TRIM_FIT: begin
            wr_en   = 1'b1;
            wr_data = '{x: sat16(pe_ff), y: rd_ff.y, w: nw[15:0]};
         end
         CMD_DROP_WR: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[IW-1:0];
         end
         CMD_MERGE_JOIN: begin
            wr_en   = 1'b1;
            wr_data = '{x: cur_ff.x, y: cur_ff.y, w: sat16(wsum)};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         aw_ff        <= '0;
         ah_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && ctl.cmd != CMD_SEND) rsp_valid_ff <= 1'b0;
         unique case (ctl.cmd)
            CMD_LOAD: begin
               act_ff <= req_data.action;
               rw_ff  <= req_data.req_width;
               rh_ff  <= req_data.req_height;
            end
            CMD_RESET_SKY: begin
               cnt_ff <= CW'(1);
               aw_ff  <= {1'b0, rw_ff};
               ah_ff  <= {1'b0, rh_ff};
            end
            CMD_EXPAND: begin
               if ({1'b0, rw_ff} > aw_ff) cnt_ff <= cnt_ff + CW'(1);
               aw_ff <= {1'b0, rw_ff};
               ah_ff <= {1'b0, rh_ff};
            end
            CMD_SRCH_INIT: begin
               s_ff        <= '0;
               best_top_ff <= {1'b0, ah_ff};
               best_w_ff   <= aw_ff;
               found_ff    <= 1'b0;
            end
            CMD_CHK_S: begin
               y_ff    <= rd_ff.y;
               left_ff <= $signed({3'b0, rw_ff});
               k_ff    <= s_ff;
               sw_ff   <= rd_ff.w;
               sx_ff   <= rd_ff.x;
            end
            CMD_NEXT_S: s_ff <= s_ff + CW'(1);
            CMD_WALK: begin
               y_ff    <= ny;
               left_ff <= left_nx;
               k_ff    <= k_ff + CW'(1);
            end
            CMD_EVAL: begin
               if (better) begin
                  found_ff    <= 1'b1;
                  best_i_ff   <= s_ff;
                  best_w_ff   <= sw_ff;
                  best_top_ff <= top;
                  best_x_ff   <= sx_ff;
                  best_y_ff   <= y_ff;
               end
               s_ff <= s_ff + CW'(1);
            end
            CMD_INS_INIT: begin
               k_ff   <= cnt_ff;
               new_ff <= '{x: best_x_ff,
                           y: sat16({1'b0, best_y_ff} + {2'b0, rh_ff}),
                           w: {1'b0, rw_ff}};
               pe_ff  <= {1'b0, best_x_ff} + {2'b0, rw_ff};
            end
            CMD_INS_WR: k_ff <= k_ff - CW'(1);
            CMD_INS_PUT: begin
               cnt_ff <= cnt_ff + CW'(1);
               k_ff   <= best_i_ff + CW'(1);
            end
            CMD_TRIM_DROP:  j_ff <= k_ff;
            CMD_DROP_WR:    j_ff <= j_next[CW-1:0];
            CMD_DROP_FIN:   cnt_ff <= cnt_ff - CW'(1);
            CMD_MERGE_INIT: k_ff <= '0;
            CMD_MERGE_RD2:  cur_ff <= rd_ff;
            CMD_MERGE_JOIN: j_ff <= k_next[CW-1:0];
            CMD_MERGE_NEXT: k_ff <= k_next[CW-1:0];
            CMD_SEND: begin
               rsp_valid_ff   <= 1'b1;
               rsp_ff.status  <= ctl.code;
               if (ctl.code == ST_OK && act_ff == ACT_ADD) begin
                  rsp_ff.place_x <= best_x_ff[14:0];
                  rsp_ff.place_y <= best_y_ff[14:0];
               end else begin
                  rsp_ff.place_x <= '0;
                  rsp_ff.place_y <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ sim/skyline_rect_packer_top_tb.sv @@
`timescale 1ns / 1ps

module skyline_rect_packer_top_tb;
   import skyp_pkg::*;

   localparam int SEG_DEPTH = MAX_SEGMENTS_DEF;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   skyline_rect_packer_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   // Shadow copy of the skyline, updated as each request transaction is accepted.
   logic [15:0] sky_x [SEG_DEPTH];
   logic [15:0] sky_y [SEG_DEPTH];
   logic [15:0] sky_w [SEG_DEPTH];
   int          sky_count = 0;
   longint      atlas_w = 0;
   longint      atlas_h = 0;

   rsp_type     pending_rsp [$];
   int          fail_count = 0;
   bit          idle_enable = 1'b1;
   int          rsp_hold_cycles = 0;

   function automatic logic [15:0] clamp16(longint v);
      if (v < 0) return 16'd0;
      if (v > 65535) return 16'hFFFF;
      return v[15:0];
   endfunction

   function automatic void seg_insert(int pos, longint x, longint y, longint w);
      for (int k = sky_count; k > pos; k--) begin
         sky_x[k] = sky_x[k-1];
         sky_y[k] = sky_y[k-1];
         sky_w[k] = sky_w[k-1];
      end
      sky_x[pos] = clamp16(x);
      sky_y[pos] = clamp16(y);
      sky_w[pos] = clamp16(w);
      sky_count++;
   endfunction

   function automatic void seg_remove(int pos);
      if (sky_count == 0) return;
      for (int k = pos; k + 1 < sky_count; k++) begin
         sky_x[k] = sky_x[k+1];
         sky_y[k] = sky_y[k+1];
         sky_w[k] = sky_w[k+1];
      end
      sky_count--;
   endfunction

   // Resting height for a rectangle starting on segment s; -1 when it does not fit.
   function automatic longint rest_height(int s, longint w, longint h);
      longint y;
      longint left;
      int     k;
      y = sky_y[s];
      left = w;
      k = s;
      if (longint'(sky_x[s]) + w > atlas_w) return -1;
      while (left > 0) begin
         if (k >= sky_count) return -1;
         if (longint'(sky_y[k]) > y) y = sky_y[k];
         if (y + h > atlas_h) return -1;
         left -= sky_w[k];
         k++;
      end
      return y;
   endfunction

   function automatic void raise_sky(int pos, longint x, longint y, longint w, longint h);
      int     k;
      longint prev_end;
      longint shrink;
      longint nw;
      seg_insert(pos, x, y + h, w);
      // trim segments that now lie under the new one
      k = pos + 1;
      while (k < sky_count) begin
         prev_end = longint'(sky_x[k-1]) + longint'(sky_w[k-1]);
         if (longint'(sky_x[k]) >= prev_end) break;
         shrink = prev_end - sky_x[k];
         nw = longint'(sky_w[k]) - shrink;
         sky_x[k] = clamp16(longint'(sky_x[k]) + shrink);
         if (nw <= 0) begin
            seg_remove(k);
         end else begin
            sky_w[k] = clamp16(nw);
            break;
         end
      end
      // merge neighbors of equal height
      k = 0;
      while (k + 1 < sky_count) begin
         if (sky_y[k] == sky_y[k+1]) begin
            sky_w[k] = clamp16(longint'(sky_w[k]) + longint'(sky_w[k+1]));
            seg_remove(k + 1);
         end else begin
            k++;
         end
      end
   endfunction

   function automatic rsp_type pack_result(req_type r);
      rsp_type o;
      longint  rw, rh, y;
      longint  best_top, best_w, best_x, best_y;
      int      best_i;
      bit      found;
      o = '0;
      o.status = ST_OK;
      rw = r.req_width;
      rh = r.req_height;
      case (r.action)
         ACT_RESET: begin
            atlas_w = rw;
            atlas_h = rh;
            sky_x[0] = 16'd0;
            sky_y[0] = 16'd0;
            sky_w[0] = rw[15:0];
            sky_count = 1;
         end
         ACT_EXPAND: begin
            if (rw > atlas_w && sky_count >= SEG_DEPTH) begin
               o.status = ST_FULL;
            end else begin
               if (rw > atlas_w) seg_insert(sky_count, atlas_w, 0, rw - atlas_w);
               atlas_w = rw;
               atlas_h = rh;
            end
         end
         ACT_ADD: begin
            best_top = atlas_h;
            best_w = atlas_w;
            best_x = 0;
            best_y = 0;
            best_i = 0;
            found = 1'b0;
            for (int k = 0; k < sky_count; k++) begin
               y = rest_height(k, rw, rh);
               if (y < 0) continue;
               if (y + rh < best_top || (y + rh == best_top && longint'(sky_w[k]) < best_w))
                  begin
                  found = 1'b1;
                  best_i = k;
                  best_w = sky_w[k];
                  best_top = y + rh;
                  best_x = sky_x[k];
                  best_y = y;
               end
            end
            if (!found) begin
               o.status = ST_NOSPACE;
            end else if (sky_count >= SEG_DEPTH) begin
               o.status = ST_FULL;
            end else begin
               raise_sky(best_i, best_x, best_y, rw, rh);
               o.place_x = best_x[14:0];
               o.place_y = best_y[14:0];
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // Offer one request; record its expected result once the transaction is accepted.
   task automatic send_req(logic [1:0] act, int w, int h);
      req_type r;
      int      gap;
      r.action = act;
      r.req_width = w[14:0];
      r.req_height = h[14:0];
      gap = (idle_enable && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(pack_result(r));
   endtask

   // Drive result-side backpressure: long hold when asked, else random bursts.
   initial begin : rsp_stall
      int burst;
      burst = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_cycles--;
         end else if (burst > 0) begin
            rsp_ready <= 1'b0;
            burst--;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_enable && $urandom_range(0, 4) == 0) burst = $urandom_range(1, 5);
         end
      end
   end

   // Compare each result transaction against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result: status %0d x %0d y %0d",
                   rsp_data.status, rsp_data.place_x, rsp_data.place_y);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.place_x !== want.place_x) begin
               $error("place_x: expected %0d, got %0d", want.place_x, rsp_data.place_x);
               fail_count++;
            end
            if (rsp_data.place_y !== want.place_y) begin
               $error("place_y: expected %0d, got %0d", want.place_y, rsp_data.place_y);
               fail_count++;
            end
         end
      end
   end

   task automatic test_corner_cases();
      send_req(ACT_ADD, 5, 5);             // empty skyline, no fit
      send_req(ACT_EXPAND, 10, 10);        // expand from nothing appends a segment
      send_req(ACT_RESET, 100, 50);
      send_req(ACT_ADD, 0, 0);             // zero-size rectangle
      send_req(ACT_ADD, 32767, 1);         // too wide
      send_req(ACT_ADD, 100, 50);          // full-height tie on a full-width segment
      send_req(ACT_ADD, 40, 20);
      send_req(ACT_ADD, 60, 20);
      send_req(ACT_ADD, 10, 10);
      send_req(ACT_ADD, 0, 5);
      send_req(ACT_EXPAND, 50, 60);        // narrower: size only
      send_req(ACT_EXPAND, 120, 60);       // wider: append segment
      send_req(ACT_ADD, 30, 40);
      send_req(ACT_ADD, 1, 61);            // too tall
      send_req(ACT_UNUSED, 32767, 32767);  // ignored action
      send_req(ACT_RESET, 32767, 32767);
      send_req(ACT_ADD, 32767, 32767);
      send_req(ACT_ADD, 32767, 0);
      send_req(ACT_RESET, 0, 0);
      send_req(ACT_ADD, 0, 0);
      send_req(ACT_EXPAND, 0, 0);
   endtask

   // Grow the atlas one column at a time until the segment table fills.
   task automatic test_full_table();
      send_req(ACT_RESET, 1, 10);
      for (int i = 2; i <= SEG_DEPTH; i++) send_req(ACT_EXPAND, i, 10);
      send_req(ACT_ADD, 1, 1);             // fit found but table full
      send_req(ACT_EXPAND, 400, 10);       // append refused
      send_req(ACT_EXPAND, 100, 20);       // narrowing still allowed
      send_req(ACT_ADD, 300, 1);
   endtask

   // Hold the result side off long enough for the block to stall its input.
   task automatic test_backpressure();
      rsp_hold_cycles = 400;
      send_req(ACT_RESET, 64, 64);
      for (int i = 0; i < 12; i++) send_req(ACT_ADD, $urandom_range(1, 16), $urandom_range(1, 16));
   endtask

   task automatic pack_session();
      int aw, ah, n;
      if ($urandom_range(0, 7) == 0) begin
         aw = $urandom_range(0, 32767);
         ah = $urandom_range(0, 32767);
      end else begin
         aw = $urandom_range(1, 64);
         ah = $urandom_range(1, 64);
      end
      send_req(ACT_RESET, aw, ah);
      n = $urandom_range(4, 16);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 19))
            0: send_req(ACT_EXPAND, $urandom_range(aw, aw + 40) & 32'h7FFF,
                        $urandom_range(ah, ah + 40) & 32'h7FFF);
            1: send_req(ACT_EXPAND, $urandom_range(0, aw), $urandom_range(0, ah));
            2: send_req(ACT_UNUSED, $urandom_range(0, 32767), $urandom_range(0, 32767));
            3: send_req(ACT_ADD, $urandom_range(0, 32767), $urandom_range(0, 32767));
            4: send_req(ACT_RESET + 2'($urandom_range(0, 2)),
                        $urandom_range(0, 32767), $urandom_range(0, 32767));
            default: send_req(ACT_ADD, $urandom_range(0, aw / 3 + 1),
                              $urandom_range(0, ah / 3 + 1));
         endcase
         if (atlas_w < 32767) aw = int'(atlas_w);
         if (atlas_h < 32767) ah = int'(atlas_h);
      end
   endtask

   task automatic test_random(int items);
      int start;
      start = 0;
      while (start < items) begin
         pack_session();
         start += 12;
      end
   endtask

   initial begin : main
      int waited;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_corner_cases();
      test_full_table();
      test_backpressure();
      test_random(800);
      idle_enable = 1'b0;
      test_random(200);
      @(negedge clock);
      req_valid <= 1'b0;
      waited = 0;
      while (pending_rsp.size() != 0 && waited < 2000000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin : watchdog
      #100ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/skyp_pkg.sv
rtl/skyp_ctrl.sv
rtl/skyp_datapath.sv
rtl/skyline_rect_packer_top.sv
sim/skyline_rect_packer_top_tb.sv
